// ===== rtl/gss_pkg.sv =====
// gss_pkg: shared types, constants and the arctangent table of the golden-section search
// depends on nothing; used by every rtl file of the block
package gss_pkg;

   localparam int unsigned MAX_STEPS    = 64;
   localparam int unsigned CORDIC_STEPS = 24;

   localparam int STEP_W = 8;    // narrowing counter, holds MAX_STEPS
   localparam int COS_W  = 34;   // cordic x, y, z and cosine, Q4.30 signed
   localparam int MAG_W  = 47;   // magnitude of the scaled angle before reduction
   localparam int ANG_W  = 35;   // angle below 2pi in Q.32
   localparam int RED_W  = 4;    // reduction shift counter
   localparam int RED_TOP = 10;  // largest shift of 2pi tried by the reduction

   localparam logic [15:0]             PSI_Q16   = 16'd40503;
   localparam logic signed [31:0]      TENTH_Q32 = 32'sd429496730;
   localparam logic [ANG_W-1:0]        TWO_PI    = 35'd26986075410;
   localparam logic [ANG_W-1:0]        PI        = 35'd13493037705;
   localparam logic [ANG_W-1:0]        HALF_PI   = 35'd6746518852;
   localparam logic signed [COS_W-1:0] KINV_Q30  = 34'sd652032874;

   localparam int TOL_W = 17;
   localparam logic [TOL_W-1:0] TOL_RESET = 17'd1;

   localparam int CSR_ADDR_W = 3;
   localparam logic REG_TOLERANCE = 1'b0;   // register index, taken from paddr[2]

   // operand / destination codes for the shared cosine unit
   localparam logic [2:0] SEL_X1  = 3'd0;
   localparam logic [2:0] SEL_X2  = 3'd1;
   localparam logic [2:0] SEL_A   = 3'd2;
   localparam logic [2:0] SEL_B   = 3'd3;
   localparam logic [2:0] SEL_MID = 3'd4;

   typedef struct packed {
      logic signed [31:0] end_a;
      logic signed [31:0] end_b;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] min_point;
      logic [6:0]         step_count;
      logic               step_limit_hit;
   } rsp_payload_type;

   typedef struct packed {
      logic       load;
      logic       off_en;
      logic       set_x1;
      logic       set_x2;
      logic       go_left;
      logic       go_right;
      logic       set_hit;
      logic       cos_start;
      logic [2:0] cos_sel;
      logic       out_load;
   } gss_cmd_type;

   typedef struct packed {
      logic gt_tol;
      logic steps_max;
      logic c1_lt_c2;
      logic cos_done;
   } gss_status_type;

   function automatic logic signed [COS_W-1:0] atan_q30(input logic [4:0] i);
      logic signed [COS_W-1:0] v;
      unique case (i)
         5'd0:  v = 34'sd843314856;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043836;
         5'd3:  v = 34'sd133525158;
         5'd4:  v = 34'sd67021686;
         5'd5:  v = 34'sd33543515;
         5'd6:  v = 34'sd16775850;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194282;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048575;
         5'd11: v = 34'sd524287;
         5'd12: v = 34'sd262143;
         5'd13: v = 34'sd131071;
         5'd14: v = 34'sd65535;
         5'd15: v = 34'sd32767;
         5'd16: v = 34'sd16383;
         5'd17: v = 34'sd8191;
         5'd18: v = 34'sd4095;
         5'd19: v = 34'sd2047;
         5'd20: v = 34'sd1023;
         5'd21: v = 34'sd511;
         5'd22: v = 34'sd255;
         5'd23: v = 34'sd127;
         5'd24: v = 34'sd63;
         5'd25: v = 34'sd31;
         5'd26: v = 34'sd15;
         5'd27: v = 34'sd7;
         5'd28: v = 34'sd3;
         5'd29: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/gss_cos.sv =====
// gss_cos: multi-cycle cosine of 0.1*x (multiply, modulo 2pi, folding, cordic rotation)
// depends on gss_pkg
module gss_cos (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [31:0]                x_in,
   output logic                              done,
   output logic signed [gss_pkg::COS_W-1:0]  cos_out
);

   localparam logic [2:0] C_IDLE  = 3'd0;
   localparam logic [2:0] C_MUL   = 3'd1;
   localparam logic [2:0] C_RED   = 3'd2;
   localparam logic [2:0] C_SIGN  = 3'd3;
   localparam logic [2:0] C_FPI   = 3'd4;
   localparam logic [2:0] C_FHALF = 3'd5;
   localparam logic [2:0] C_ROT   = 3'd6;

   logic [2:0] st_ff, st_in;
   logic signed [31:0] x_ff, x_in_d;
   logic [gss_pkg::MAG_W-1:0] mag_ff, mag_in;
   logic rneg_ff, rneg_in;
   logic [gss_pkg::RED_W-1:0] k_ff, k_in;
   logic [gss_pkg::ANG_W-1:0] ang_ff, ang_in;
   logic neg_ff, neg_in;
   logic signed [gss_pkg::COS_W-1:0] cx_ff, cx_in, cy_ff, cy_in, z_ff, z_in;
   logic [4:0] i_ff, i_in;
   logic done_ff, done_in;
   logic signed [gss_pkg::COS_W-1:0] cos_ff, cos_in;

   logic signed [62:0] prod;
   logic signed [gss_pkg::MAG_W-1:0] r_scaled;
   logic [gss_pkg::MAG_W-1:0] sub_val;
   logic signed [gss_pkg::COS_W-1:0] dx, dy, at;
   logic [gss_pkg::ANG_W-1:0] ang_half;

   assign prod     = x_ff * gss_pkg::TENTH_Q32;
   assign r_scaled = prod[62:16];   // floor shift by 16
   assign sub_val  = {{(gss_pkg::MAG_W-gss_pkg::ANG_W){1'b0}}, gss_pkg::TWO_PI} << k_ff;
   assign dx       = cy_ff >>> i_ff;
   assign dy       = cx_ff >>> i_ff;
   assign at       = gss_pkg::atan_q30(i_ff);
   assign ang_half = gss_pkg::PI - ang_ff;

   always_comb begin
      st_in   = st_ff;
      x_in_d  = x_ff;
      mag_in  = mag_ff;
      rneg_in = rneg_ff;
      k_in    = k_ff;
      ang_in  = ang_ff;
      neg_in  = neg_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      done_in = 1'b0;
      cos_in  = cos_ff;
      unique case (st_ff)
         C_IDLE: begin
            if (start) begin
               x_in_d = x_in;
               st_in  = C_MUL;
            end
         end
         C_MUL: begin
            rneg_in = r_scaled[gss_pkg::MAG_W-1];
            mag_in  = r_scaled[gss_pkg::MAG_W-1] ? gss_pkg::MAG_W'(-r_scaled)
                                                 : gss_pkg::MAG_W'(r_scaled);
            k_in    = gss_pkg::RED_W'(gss_pkg::RED_TOP);
            st_in   = C_RED;
         end
         C_RED: begin
            if (mag_ff >= sub_val) begin
               mag_in = mag_ff - sub_val;
            end
            k_in = k_ff - 1'b1;
            if (k_ff == '0) begin
               st_in = C_SIGN;
            end
         end
         C_SIGN: begin
            // negative angle: floor modulo
            if (rneg_ff && (mag_ff != '0)) begin
               ang_in = gss_pkg::TWO_PI - mag_ff[gss_pkg::ANG_W-1:0];
            end else begin
               ang_in = mag_ff[gss_pkg::ANG_W-1:0];
            end
            st_in = C_FPI;
         end
         C_FPI: begin
            if (ang_ff > gss_pkg::PI) begin
               ang_in = gss_pkg::TWO_PI - ang_ff;
            end
            st_in = C_FHALF;
         end
         C_FHALF: begin
            if (ang_ff > gss_pkg::HALF_PI) begin
               neg_in = 1'b1;
               z_in   = gss_pkg::COS_W'(ang_half >> 2);
            end else begin
               neg_in = 1'b0;
               z_in   = gss_pkg::COS_W'(ang_ff >> 2);
            end
            cx_in = gss_pkg::KINV_Q30;
            cy_in = '0;
            i_in  = '0;
            st_in = C_ROT;
         end
         C_ROT: begin
            if (!z_ff[gss_pkg::COS_W-1]) begin
               cx_in = cx_ff - dx;
               cy_in = cy_ff + dy;
               z_in  = z_ff - at;
            end else begin
               cx_in = cx_ff + dx;
               cy_in = cy_ff - dy;
               z_in  = z_ff + at;
            end
            i_in = i_ff + 1'b1;
            if (i_ff == 5'(gss_pkg::CORDIC_STEPS - 1)) begin
               done_in = 1'b1;
               cos_in  = neg_ff ? -cx_in : cx_in;
               st_in   = C_IDLE;
            end
         end
         default: begin
            st_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= C_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in_d;
      mag_ff  <= mag_in;
      rneg_ff <= rneg_in;
      k_ff    <= k_in;
      ang_ff  <= ang_in;
      neg_ff  <= neg_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      z_ff    <= z_in;
      i_ff    <= i_in;
      cos_ff  <= cos_in;
   end

   assign done    = done_ff;
   assign cos_out = cos_ff;

endmodule

// ===== rtl/gss_datapath.sv =====
// gss_datapath: interval, probe and cosine registers, probe offset multiplier, result register
// depends on gss_pkg and gss_cos
module gss_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  gss_pkg::gss_cmd_type          cmd,
   output gss_pkg::gss_status_type       status,
   input  gss_pkg::req_payload_type      req_data,
   input  logic [gss_pkg::TOL_W-1:0]     tolerance,
   output gss_pkg::rsp_payload_type      rsp_data
);

   logic signed [31:0] a_ff, b_ff, x1_ff, x2_ff;
   logic signed [gss_pkg::COS_W-1:0] c1_ff, c2_ff, ca_ff, cb_ff, cm_ff;
   logic [31:0] off_ff;
   logic [gss_pkg::STEP_W-1:0] steps_ff;
   logic hit_ff;
   logic [2:0] sel_ff;
   gss_pkg::rsp_payload_type out_ff;

   logic [32:0] width;
   logic [48:0] off_prod;
   logic [33:0] x1_wide, x2_wide, mid_wide;
   logic signed [31:0] mid, cos_arg;
   logic cos_done;
   logic signed [gss_pkg::COS_W-1:0] cos_val;
   logic signed [31:0] best;
   logic [gss_pkg::STEP_W-1:0] count_rep;

   assign width    = 33'({b_ff[31], b_ff} - {a_ff[31], a_ff});
   assign off_prod = width * gss_pkg::PSI_Q16;
   assign x1_wide  = {{2{b_ff[31]}}, b_ff} - {2'b00, off_ff};
   assign x2_wide  = {{2{a_ff[31]}}, a_ff} + {2'b00, off_ff};
   assign mid_wide = {{2{a_ff[31]}}, a_ff} + {2'b00, width[32:1]};
   assign mid      = mid_wide[31:0];

   always_comb begin
      unique case (cmd.cos_sel)
         gss_pkg::SEL_X1: cos_arg = x1_ff;
         gss_pkg::SEL_X2: cos_arg = x2_ff;
         gss_pkg::SEL_A:  cos_arg = a_ff;
         gss_pkg::SEL_B:  cos_arg = b_ff;
         default:         cos_arg = mid;
      endcase
   end

   gss_cos u_cos (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.cos_start),
      .x_in    (cos_arg),
      .done    (cos_done),
      .cos_out (cos_val)
   );

   // lowest f is highest cosine; any tie, also one between the two ends alone, picks the midpoint
   always_comb begin
      priority if ((ca_ff > cb_ff) && (ca_ff > cm_ff)) begin
         best = a_ff;
      end else if ((cb_ff > ca_ff) && (cb_ff > cm_ff)) begin
         best = b_ff;
      end else begin
         best = mid;
      end
   end

   assign count_rep = steps_ff + gss_pkg::STEP_W'(2);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (req_data.end_a > req_data.end_b) begin
            a_ff <= req_data.end_b;
            b_ff <= req_data.end_a;
         end else begin
            a_ff <= req_data.end_a;
            b_ff <= req_data.end_b;
         end
         steps_ff <= '0;
         hit_ff   <= 1'b0;
      end else if (cmd.go_left) begin
         a_ff     <= x1_ff;
         x1_ff    <= x2_ff;
         c1_ff    <= c2_ff;
         steps_ff <= steps_ff + 1'b1;
      end else if (cmd.go_right) begin
         b_ff     <= x2_ff;
         x2_ff    <= x1_ff;
         c2_ff    <= c1_ff;
         steps_ff <= steps_ff + 1'b1;
      end
      if (cmd.set_hit) begin
         hit_ff <= 1'b1;
      end
      if (cmd.off_en) begin
         off_ff <= off_prod[47:16];
      end
      if (cmd.set_x1) begin
         x1_ff <= x1_wide[31:0];
      end
      if (cmd.set_x2) begin
         x2_ff <= x2_wide[31:0];
      end
      if (cmd.cos_start) begin
         sel_ff <= cmd.cos_sel;
      end
      if (cos_done) begin
         unique case (sel_ff)
            gss_pkg::SEL_X1: c1_ff <= cos_val;
            gss_pkg::SEL_X2: c2_ff <= cos_val;
            gss_pkg::SEL_A:  ca_ff <= cos_val;
            gss_pkg::SEL_B:  cb_ff <= cos_val;
            default:         cm_ff <= cos_val;
         endcase
      end
      if (cmd.out_load) begin
         out_ff.min_point      <= best;
         out_ff.step_count     <= count_rep[6:0];
         out_ff.step_limit_hit <= hit_ff;
      end
   end

   assign status.gt_tol    = width > {15'd0, tolerance, 1'b0};
   assign status.steps_max = steps_ff >= gss_pkg::STEP_W'(gss_pkg::MAX_STEPS);
   assign status.c1_lt_c2  = c1_ff < c2_ff;
   assign status.cos_done  = cos_done;
   assign rsp_data         = out_ff;

endmodule

// ===== rtl/gss_ctrl.sv =====
// gss_ctrl: sequencer of the search, handshakes on both channels
// depends on gss_pkg
module gss_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  gss_pkg::gss_status_type  status,
   output gss_pkg::gss_cmd_type     cmd
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_OFF0 = 5'd1;
   localparam logic [4:0] S_SETX = 5'd2;
   localparam logic [4:0] S_C1   = 5'd3;
   localparam logic [4:0] S_W1   = 5'd4;
   localparam logic [4:0] S_C2   = 5'd5;
   localparam logic [4:0] S_WCHK = 5'd6;
   localparam logic [4:0] S_CHK  = 5'd7;
   localparam logic [4:0] S_OFFL = 5'd8;
   localparam logic [4:0] S_SETL = 5'd9;
   localparam logic [4:0] S_CL   = 5'd10;
   localparam logic [4:0] S_OFFR = 5'd11;
   localparam logic [4:0] S_SETR = 5'd12;
   localparam logic [4:0] S_CR   = 5'd13;
   localparam logic [4:0] S_FA   = 5'd14;
   localparam logic [4:0] S_WA   = 5'd15;
   localparam logic [4:0] S_FB   = 5'd16;
   localparam logic [4:0] S_WB   = 5'd17;
   localparam logic [4:0] S_FM   = 5'd18;
   localparam logic [4:0] S_WM   = 5'd19;
   localparam logic [4:0] S_OUT  = 5'd20;

   logic [4:0] state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.cos_sel  = gss_pkg::SEL_X1;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_OFF0;
            end
         end
         S_OFF0: begin
            cmd.off_en = 1'b1;
            state_in   = S_SETX;
         end
         S_SETX: begin
            cmd.set_x1 = 1'b1;
            cmd.set_x2 = 1'b1;
            state_in   = S_C1;
         end
         S_C1: begin
            cmd.cos_start = 1'b1;
            cmd.cos_sel   = gss_pkg::SEL_X1;
            state_in      = S_W1;
         end
         S_W1: begin
            if (status.cos_done) begin
               state_in = S_C2;
            end
         end
         S_C2: begin
            cmd.cos_start = 1'b1;
            cmd.cos_sel   = gss_pkg::SEL_X2;
            state_in      = S_WCHK;
         end
         S_WCHK: begin
            if (status.cos_done) begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            priority if (!status.gt_tol) begin
               state_in = S_FA;
            end else if (status.steps_max) begin
               cmd.set_hit = 1'b1;
               state_in    = S_FA;
            end else if (status.c1_lt_c2) begin
               cmd.go_left = 1'b1;
               state_in    = S_OFFL;
            end else begin
               cmd.go_right = 1'b1;
               state_in     = S_OFFR;
            end
         end
         S_OFFL: begin
            cmd.off_en = 1'b1;
            state_in   = S_SETL;
         end
         S_SETL: begin
            cmd.set_x2 = 1'b1;
            state_in   = S_CL;
         end
         S_CL: begin
            cmd.cos_start = 1'b1;
            cmd.cos_sel   = gss_pkg::SEL_X2;
            state_in      = S_WCHK;
         end
         S_OFFR: begin
            cmd.off_en = 1'b1;
            state_in   = S_SETR;
         end
         S_SETR: begin
            cmd.set_x1 = 1'b1;
            state_in   = S_CR;
         end
         S_CR: begin
            cmd.cos_start = 1'b1;
            cmd.cos_sel   = gss_pkg::SEL_X1;
            state_in      = S_WCHK;
         end
         S_FA: begin
            cmd.cos_start = 1'b1;
            cmd.cos_sel   = gss_pkg::SEL_A;
            state_in      = S_WA;
         end
         S_WA: begin
            if (status.cos_done) begin
               state_in = S_FB;
            end
         end
         S_FB: begin
            cmd.cos_start = 1'b1;
            cmd.cos_sel   = gss_pkg::SEL_B;
            state_in      = S_WB;
         end
         S_WB: begin
            if (status.cos_done) begin
               state_in = S_FM;
            end
         end
         S_FM: begin
            cmd.cos_start = 1'b1;
            cmd.cos_sel   = gss_pkg::SEL_MID;
            state_in      = S_WM;
         end
         S_WM: begin
            if (status.cos_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/golden_section_minimum_search.sv =====
// golden-section search for the minimum of 2 - cos(0.1 x) over one Q16.16 interval
// one interval at a time, with up to 64 narrowings; the next input is taken once the result
//   of the last has been loaded into the result register
// pace set by the shared cosine unit, which works through one cosine at a time (start, multiply,
//   reduction, folding, cordic rotation, done), five cosines per item plus one per narrowing step
// reset: synchronous, active high; clears the sequencer and sets tolerance to 1
module golden_section_minimum_search (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  gss_pkg::req_payload_type            req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output gss_pkg::rsp_payload_type            rsp_data,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gss_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   gss_pkg::gss_cmd_type    cmd;
   gss_pkg::gss_status_type status;

   logic [gss_pkg::TOL_W-1:0] tol_ff;
   logic csr_write;

   // register file: only the tolerance word, picked by the word index bit of the address
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == gss_pkg::REG_TOLERANCE);

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= gss_pkg::TOL_RESET;
      end else if (csr_write) begin
         tol_ff <= csr_pwdata[gss_pkg::TOL_W-1:0];
      end
   end

   // reads of other words return zero
   assign csr_prdata = (csr_paddr[2] == gss_pkg::REG_TOLERANCE)
                       ? {15'd0, tol_ff} : 32'd0;

   // sequencer: walks load, probe setup, narrowing loop and final three-way compare
   gss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: interval registers, probe offset multiplier, cosine unit, result register
   gss_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .tolerance (tol_ff),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // after a transfer in, the block is not ready again in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a second interval right after the first");

   // cosine results only arrive while a search is in flight
   assert property (@(posedge clock) disable iff (reset)
      status.cos_done |-> !req_ready)
      else $error("cosine finished while idle");

   // hitting the step limit means exactly the maximum number of narrowings
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.step_limit_hit |->
         rsp_data.step_count == 7'(gss_pkg::MAX_STEPS + 2))
      else $error("step limit flagged with the wrong count");
`endif

endmodule
